FILE: hw/rtl/ams_pkg.sv
// ============================================================================
// Accumulator machine step: shared package
// Field types, memory geometry, item and opcode codes, flag masks.
// ============================================================================
`default_nettype none

package ams_pkg;

    // Memory geometry
    localparam int MEM_WORDS = 100;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    // Field widths
    localparam int WORD_W = 16;
    localparam int ADDR_W = 7;
    localparam int FLAG_W = 4;
    localparam int OPC_W  = 7;

    // Item operation codes
    localparam logic [1:0] OPER_WRITE = 2'd0;
    localparam logic [1:0] OPER_READ  = 2'd1;
    localparam logic [1:0] OPER_EXEC  = 2'd2;
    localparam logic [1:0] OPER_CLEAR = 2'd3;

    // Instruction opcodes
    localparam logic [OPC_W-1:0] OPC_READ  = 7'h10;
    localparam logic [OPC_W-1:0] OPC_WRITE = 7'h11;
    localparam logic [OPC_W-1:0] OPC_LOAD  = 7'h20;
    localparam logic [OPC_W-1:0] OPC_STORE = 7'h21;
    localparam logic [OPC_W-1:0] OPC_ADD   = 7'h30;
    localparam logic [OPC_W-1:0] OPC_SUB   = 7'h31;
    localparam logic [OPC_W-1:0] OPC_DIV   = 7'h32;
    localparam logic [OPC_W-1:0] OPC_MUL   = 7'h33;
    localparam logic [OPC_W-1:0] OPC_JUMP  = 7'h40;
    localparam logic [OPC_W-1:0] OPC_JNEG  = 7'h41;
    localparam logic [OPC_W-1:0] OPC_JZ    = 7'h42;
    localparam logic [OPC_W-1:0] OPC_HALT  = 7'h43;
    localparam logic [OPC_W-1:0] OPC_JNS   = 7'h55;

    // Sticky flag masks
    localparam logic [FLAG_W-1:0] FLAG_OOM  = 4'b0001;
    localparam logic [FLAG_W-1:0] FLAG_DIV0 = 4'b0010;
    localparam logic [FLAG_W-1:0] FLAG_CMD  = 4'b0100;
    localparam logic [FLAG_W-1:0] FLAG_CLK  = 4'b1000;

    // Input item
    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
    } t_item;

    // Result item
    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              print_valid;
        logic [ADDR_W-1:0] print_address;
        logic [WORD_W-1:0] print_value;
        logic              halted;
        logic [WORD_W-1:0] acc_value;
        logic [ADDR_W-1:0] counter_value;
        logic [FLAG_W-1:0] flag_bits;
    } t_result;

    // Memory port request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [MEM_AW-1:0] addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_req;

    // Address lies inside the memory
    function automatic logic addr_ok(input logic [ADDR_W-1:0] a);
        return {1'b0, a} < (ADDR_W + 1)'(MEM_WORDS);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ams_mem.sv
// ============================================================================
// Accumulator machine step: main memory
// Single-port word memory, registered read data, per-word valid bits so
// that words never written since reset read as zero.
// ============================================================================
`default_nettype none

module ams_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ams_pkg::t_mem_req          i_req,
    output logic [ams_pkg::WORD_W-1:0]      o_rd_data
);

    logic [ams_pkg::WORD_W-1:0]    r_mem [ams_pkg::MEM_WORDS];
    logic [ams_pkg::MEM_WORDS-1:0] r_vld;
    logic [ams_pkg::WORD_W-1:0]    r_rd_data;
    logic                          r_rd_vld;

    // Word array, write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/ams_div.sv
// ============================================================================
// Accumulator machine step: divider
// Restoring unsigned divide, one quotient bit per cycle. Divisor is nonzero.
// ============================================================================
`default_nettype none

module ams_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ams_pkg::WORD_W-1:0] i_dividend,
    input  wire logic [ams_pkg::WORD_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ams_pkg::WORD_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(ams_pkg::WORD_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [ams_pkg::WORD_W-1:0]  r_rem;
    logic [ams_pkg::WORD_W-1:0]  r_quot;
    logic [ams_pkg::WORD_W-1:0]  r_dvs;
    logic [ams_pkg::WORD_W:0]    c_rem_sh;
    logic [ams_pkg::WORD_W:0]    c_diff;
    logic                        c_ge;

    // One shift-subtract step
    assign c_rem_sh = {r_rem, r_quot[ams_pkg::WORD_W-1]};
    assign c_ge     = c_rem_sh >= {1'b0, r_dvs};
    assign c_diff   = c_rem_sh - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ams_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= c_ge ? c_diff[ams_pkg::WORD_W-1:0] : c_rem_sh[ams_pkg::WORD_W-1:0];
            r_quot <= {r_quot[ams_pkg::WORD_W-2:0], c_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: hw/rtl/accumulator_machine_step_core.sv
// ============================================================================
// Accumulator machine step core
// Runs one memory access, one instruction or one clear per item against a
// word memory, an accumulator, a program counter and sticky flags.
// ============================================================================
//
//  channel | ports                       | transfer
//  --------+-----------------------------+-----------------------------------
//  item    | start, busy, i_item         | edge with start high, busy low
//  result  | o_valid, o_result           | edge ending the o_valid cycle
//
//  Steps per item: word write and clear finish in dispatch; word read adds a
//  read-data state (not outside memory); an instruction adds fetch (not with
//  the counter outside memory), then operand where it reads one; MUL adds a
//  product state and DIVIDE the 16-step divider loop unless the divisor is zero.
//  busy is high from the transfer until the result cycle; a new item may be
//  taken in the cycle the result is shown.
//  Reset is synchronous; memory words read as zero until first written.
//  The receiver cannot stall; each result is shown for exactly one cycle.
//  Only one item is in flight, so memory reads and writes never overlap.
// ============================================================================
`default_nettype none

module accumulator_machine_step_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ams_pkg::t_item     i_item,
    output logic                    o_valid,
    output ams_pkg::t_result        o_result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_RDW   = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_OPND  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    t_state                              r_state, n_state;
    ams_pkg::t_item                      r_item, n_item;
    logic [ams_pkg::WORD_W-1:0]          r_acc, n_acc;
    logic [ams_pkg::ADDR_W-1:0]          r_pc, n_pc;
    logic [ams_pkg::FLAG_W-1:0]          r_flags, n_flags;
    logic [ams_pkg::OPC_W-1:0]           r_opc, n_opc;
    logic [ams_pkg::ADDR_W-1:0]          r_opd, n_opd;
    logic                                r_oor, n_oor;
    logic [2*ams_pkg::WORD_W-1:0]        r_prod, n_prod;
    logic                                r_valid, n_valid;
    ams_pkg::t_result                    r_res, n_res;

    ams_pkg::t_mem_req                   c_mem_req;
    logic [ams_pkg::WORD_W-1:0]          c_mem_rdata;
    logic                                c_div_start;
    logic                                c_div_done;
    logic [ams_pkg::WORD_W-1:0]          c_div_quot;

    logic                                c_fin;
    logic [ams_pkg::WORD_W-1:0]          c_rd;
    logic                                c_pv;
    logic [ams_pkg::ADDR_W-1:0]          c_pa;
    logic [ams_pkg::WORD_W-1:0]          c_pval;
    logic                                c_halt;
    logic [ams_pkg::WORD_W-1:0]          c_m;
    logic [ams_pkg::WORD_W:0]            c_sum;
    logic [ams_pkg::ADDR_W-1:0]          c_pc_inc;
    logic [ams_pkg::OPC_W-1:0]           c_opc;
    logic [ams_pkg::ADDR_W-1:0]          c_opd;

    ams_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (c_mem_req),
        .o_rd_data (c_mem_rdata)
    );

    ams_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (r_acc),
        .i_divisor  (c_m),
        .o_done     (c_div_done),
        .o_quot     (c_div_quot)
    );

    assign c_pc_inc = r_pc + ams_pkg::ADDR_W'(1);
    assign c_opc    = c_mem_rdata[ams_pkg::OPC_W+ams_pkg::ADDR_W-1:ams_pkg::ADDR_W];
    assign c_opd    = c_mem_rdata[ams_pkg::ADDR_W-1:0];
    assign c_m      = r_oor ? '0 : c_mem_rdata;
    assign c_sum    = {1'b0, r_acc} + {1'b0, c_m};

    // Sequencer: dispatch, fetch, operand read, execute, write back
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_acc       = r_acc;
        n_pc        = r_pc;
        n_flags     = r_flags;
        n_opc       = r_opc;
        n_opd       = r_opd;
        n_oor       = r_oor;
        n_prod      = r_prod;
        c_mem_req   = '0;
        c_div_start = 1'b0;
        c_fin       = 1'b0;
        c_rd        = '0;
        c_pv        = 1'b0;
        c_pa        = '0;
        c_pval      = '0;
        c_halt      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                case (r_item.operation)
                    ams_pkg::OPER_WRITE: begin
                        if (ams_pkg::addr_ok(r_item.address)) begin
                            c_mem_req.wr_en   = 1'b1;
                            c_mem_req.addr    = r_item.address[ams_pkg::MEM_AW-1:0];
                            c_mem_req.wr_data = r_item.data;
                        end else begin
                            n_flags = r_flags | ams_pkg::FLAG_OOM;
                        end
                        c_fin = 1'b1;
                    end
                    ams_pkg::OPER_READ: begin
                        if (ams_pkg::addr_ok(r_item.address)) begin
                            c_mem_req.rd_en = 1'b1;
                            c_mem_req.addr  = r_item.address[ams_pkg::MEM_AW-1:0];
                            n_state         = S_RDW;
                        end else begin
                            n_flags = r_flags | ams_pkg::FLAG_OOM;
                            c_fin   = 1'b1;
                        end
                    end
                    ams_pkg::OPER_CLEAR: begin
                        n_flags = '0;
                        n_pc    = '0;
                        c_fin   = 1'b1;
                    end
                    ams_pkg::OPER_EXEC: begin
                        if (ams_pkg::addr_ok(r_pc)) begin
                            c_mem_req.rd_en = 1'b1;
                            c_mem_req.addr  = r_pc[ams_pkg::MEM_AW-1:0];
                            n_state         = S_FETCH;
                        end else begin
                            // fetch outside memory reads as a zero word
                            n_flags = r_flags | ams_pkg::FLAG_OOM | ams_pkg::FLAG_CMD
                                    | ams_pkg::FLAG_CLK;
                            c_fin   = 1'b1;
                        end
                    end
                    default: begin
                        c_fin = 1'b1;
                    end
                endcase
            end

            S_RDW: begin
                c_rd  = c_mem_rdata;
                c_fin = 1'b1;
            end

            S_FETCH: begin
                n_opc = c_opc;
                n_opd = c_opd;
                if (c_mem_rdata == '0) begin
                    // empty word: nothing runs, counter holds
                    n_flags = r_flags | ams_pkg::FLAG_CMD | ams_pkg::FLAG_CLK;
                    c_fin   = 1'b1;
                end else begin
                    case (c_opc)
                        ams_pkg::OPC_READ, ams_pkg::OPC_STORE: begin
                            if (ams_pkg::addr_ok(c_opd)) begin
                                c_mem_req.wr_en   = 1'b1;
                                c_mem_req.addr    = c_opd[ams_pkg::MEM_AW-1:0];
                                c_mem_req.wr_data = (c_opc == ams_pkg::OPC_READ) ?
                                                    r_item.data : r_acc;
                            end else begin
                                n_flags = r_flags | ams_pkg::FLAG_OOM;
                            end
                            n_pc  = c_pc_inc;
                            c_fin = 1'b1;
                        end
                        ams_pkg::OPC_WRITE, ams_pkg::OPC_LOAD, ams_pkg::OPC_ADD,
                        ams_pkg::OPC_SUB, ams_pkg::OPC_DIV, ams_pkg::OPC_MUL: begin
                            // operand read; outside memory it reads as zero
                            if (ams_pkg::addr_ok(c_opd)) begin
                                c_mem_req.rd_en = 1'b1;
                                c_mem_req.addr  = c_opd[ams_pkg::MEM_AW-1:0];
                                n_oor           = 1'b0;
                            end else begin
                                n_flags = r_flags | ams_pkg::FLAG_OOM;
                                n_oor   = 1'b1;
                            end
                            n_state = S_OPND;
                        end
                        ams_pkg::OPC_JUMP: begin
                            n_pc  = c_opd;
                            c_fin = 1'b1;
                        end
                        ams_pkg::OPC_JNEG: begin
                            n_pc  = c_pc_inc;
                            c_fin = 1'b1;
                        end
                        ams_pkg::OPC_JZ: begin
                            n_pc  = (r_acc == '0) ? c_opd : c_pc_inc;
                            c_fin = 1'b1;
                        end
                        ams_pkg::OPC_JNS: begin
                            n_pc  = (r_acc != '0) ? c_opd : c_pc_inc;
                            c_fin = 1'b1;
                        end
                        ams_pkg::OPC_HALT: begin
                            c_halt = 1'b1;
                            c_fin  = 1'b1;
                        end
                        default: begin
                            n_flags = r_flags | ams_pkg::FLAG_CMD;
                            n_pc    = c_pc_inc;
                            c_fin   = 1'b1;
                        end
                    endcase
                end
            end

            S_OPND: begin
                case (r_opc)
                    ams_pkg::OPC_WRITE: begin
                        c_pv   = 1'b1;
                        c_pa   = r_opd;
                        c_pval = c_m;
                        n_pc   = c_pc_inc;
                        c_fin  = 1'b1;
                    end
                    ams_pkg::OPC_LOAD: begin
                        n_acc = c_m;
                        n_pc  = c_pc_inc;
                        c_fin = 1'b1;
                    end
                    ams_pkg::OPC_ADD: begin
                        if (!c_sum[ams_pkg::WORD_W]) begin
                            n_acc = c_sum[ams_pkg::WORD_W-1:0];
                        end
                        n_pc  = c_pc_inc;
                        c_fin = 1'b1;
                    end
                    ams_pkg::OPC_SUB: begin
                        if (c_m <= r_acc) begin
                            n_acc = r_acc - c_m;
                        end
                        n_pc  = c_pc_inc;
                        c_fin = 1'b1;
                    end
                    ams_pkg::OPC_DIV: begin
                        if (c_m == '0) begin
                            n_flags = r_flags | ams_pkg::FLAG_DIV0;
                            n_pc    = c_pc_inc;
                            c_fin   = 1'b1;
                        end else begin
                            c_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                    ams_pkg::OPC_MUL: begin
                        n_prod  = (2*ams_pkg::WORD_W)'(r_acc) * (2*ams_pkg::WORD_W)'(c_m);
                        n_state = S_MUL;
                    end
                    default: begin
                        n_pc  = c_pc_inc;
                        c_fin = 1'b1;
                    end
                endcase
            end

            S_MUL: begin
                // a product wider than one word is dropped; the accumulator keeps its value
                if (r_prod[2*ams_pkg::WORD_W-1:ams_pkg::WORD_W] == '0) begin
                    n_acc = r_prod[ams_pkg::WORD_W-1:0];
                end
                n_pc  = c_pc_inc;
                c_fin = 1'b1;
            end

            S_DIV: begin
                if (c_div_done) begin
                    n_acc = c_div_quot;
                    n_pc  = c_pc_inc;
                    c_fin = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (c_fin) begin
            n_state = S_IDLE;
        end
    end

    // Result assembly
    always_comb begin
        n_valid = c_fin;
        n_res   = r_res;
        if (c_fin) begin
            n_res.read_data     = c_rd;
            n_res.print_valid   = c_pv;
            n_res.print_address = c_pa;
            n_res.print_value   = c_pval;
            n_res.halted        = c_halt;
            n_res.acc_value     = n_acc;
            n_res.counter_value = n_pc;
            n_res.flag_bits     = n_flags;
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_pc    <= '0;
            r_flags <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            r_flags <= n_flags;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_opc  <= n_opc;
        r_opd  <= n_opd;
        r_oor  <= n_oor;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on two cycles in a row");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item transfer did not raise busy");

    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(c_mem_req.rd_en && c_mem_req.wr_en))
        else $error("memory read and write in the same cycle");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_div_start |=> (r_state == S_DIV) && !c_div_done)
        else $error("divider start without divide wait");
`endif

endmodule

`default_nettype wire

FILE: tb/ams_step_checker.sv
// ============================================================================
// Accumulator machine step: result checker
// Watches the item and result channels of the core, runs its own model of
// the machine for every item transfer and compares each result, field by
// field, with the oldest outcome still waiting.
// ============================================================================

module ams_step_checker
    import ams_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_valid,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] WORD_MAX    = 32'h0000_FFFF;
    localparam int          PRINT_LIMIT = 50;

    // Model state
    logic [WORD_W-1:0] mem_img [0:MEM_WORDS-1];
    logic [WORD_W-1:0] acc_q;
    logic [ADDR_W-1:0] pc_q;
    logic [FLAG_W-1:0] flags_q;

    // Outcomes of accepted items, oldest first
    t_result machine_outcomes [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // One line per mismatch; printing stops after PRINT_LIMIT (50) lines, counting does not
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (o_fail_count < PRINT_LIMIT)
            $display("%0t ns: %s: want 0x%0h, got 0x%0h", $time, what, want, got);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch(name, want, got);
    endtask

    // Memory access; anything at or past the end raises out-of-memory
    function automatic logic [WORD_W-1:0] load_word(input logic [ADDR_W-1:0] a);
        if (int'(a) < MEM_WORDS)
            return mem_img[a];
        flags_q |= FLAG_OOM;
        return '0;
    endfunction

    function automatic void store_word(input logic [ADDR_W-1:0] a,
                                       input logic [WORD_W-1:0] v);
        if (int'(a) < MEM_WORDS)
            mem_img[a] = v;
        else
            flags_q |= FLAG_OOM;
    endfunction

    // Applies one item to the model and returns the result it produces
    function automatic t_result machine_step(input t_item it);
        t_result           r;
        logic [WORD_W-1:0] cmd;
        logic [WORD_W-1:0] m;
        logic [OPC_W-1:0]  opc;
        logic [ADDR_W-1:0] opd;
        logic [31:0]       wide;
        logic              jump;
        logic              hold;

        r = '0;
        case (it.operation)
            OPER_WRITE: store_word(it.address, it.data);
            OPER_READ:  r.read_data = load_word(it.address);
            OPER_CLEAR: begin
                flags_q = '0;
                pc_q    = '0;
            end
            default: begin
                cmd = load_word(pc_q);
                if (cmd == '0) begin
                    // empty word: nothing runs, counter holds
                    flags_q |= FLAG_CMD | FLAG_CLK;
                end else begin
                    opc  = cmd[13:7];
                    opd  = cmd[6:0];
                    jump = 1'b0;
                    hold = 1'b0;
                    case (opc)
                        OPC_READ:  store_word(opd, it.data);
                        OPC_WRITE: begin
                            r.print_valid   = 1'b1;
                            r.print_address = opd;
                            r.print_value   = load_word(opd);
                        end
                        OPC_LOAD:  acc_q = load_word(opd);
                        OPC_STORE: store_word(opd, acc_q);
                        OPC_ADD: begin
                            wide = 32'(acc_q) + 32'(load_word(opd));
                            if (wide <= WORD_MAX)
                                acc_q = wide[WORD_W-1:0];
                        end
                        OPC_SUB: begin
                            m = load_word(opd);
                            if (m <= acc_q)
                                acc_q = acc_q - m;
                        end
                        OPC_DIV: begin
                            m = load_word(opd);
                            if (m == '0)
                                flags_q |= FLAG_DIV0;
                            else
                                acc_q = acc_q / m;
                        end
                        OPC_MUL: begin
                            wide = 32'(acc_q) * 32'(load_word(opd));
                            if (wide <= WORD_MAX)
                                acc_q = wide[WORD_W-1:0];
                        end
                        OPC_JUMP: jump = 1'b1;
                        OPC_JNEG: jump = 1'b0;  // accumulator is never negative
                        OPC_JZ:   jump = (acc_q == '0);
                        OPC_JNS:  jump = (acc_q != '0);
                        OPC_HALT: begin
                            r.halted = 1'b1;
                            hold     = 1'b1;
                        end
                        default:  flags_q |= FLAG_CMD;
                    endcase
                    if (jump)
                        pc_q = opd;
                    else if (!hold)
                        pc_q = pc_q + 1'b1;
                end
            end
        endcase
        r.acc_value     = acc_q;
        r.counter_value = pc_q;
        r.flag_bits     = flags_q;
        return r;
    endfunction

    // Channel monitor: result transfer first, then the item transfer
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++)
                mem_img[i] = '0;
            acc_q   = '0;
            pc_q    = '0;
            flags_q = '0;
            machine_outcomes.delete();
        end else begin
            if (i_valid) begin
                if (machine_outcomes.size() == 0) begin
                    report_mismatch("result with no item outstanding", 32'h0,
                                    32'(i_result.acc_value));
                end else begin
                    want = machine_outcomes.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(i_result.read_data));
                    check_field("print_valid", 32'(want.print_valid),
                                32'(i_result.print_valid));
                    check_field("print_address", 32'(want.print_address),
                                32'(i_result.print_address));
                    check_field("print_value", 32'(want.print_value),
                                32'(i_result.print_value));
                    check_field("halted", 32'(want.halted), 32'(i_result.halted));
                    check_field("acc_value", 32'(want.acc_value), 32'(i_result.acc_value));
                    check_field("counter_value", 32'(want.counter_value),
                                32'(i_result.counter_value));
                    check_field("flag_bits", 32'(want.flag_bits), 32'(i_result.flag_bits));
                end
            end
            if (i_start && !i_busy)
                machine_outcomes.push_back(machine_step(i_item));
        end
        o_pending = machine_outcomes.size();
    end

endmodule

FILE: tb/tb_accumulator_machine_step_core.sv
// ============================================================================
// Accumulator machine step core: testbench
// Directed items hit memory bounds, the empty word, overflow, underflow,
// divide by zero and the unknown opcode; random phases then load short
// programs, run them and mix in raw items. A checker module predicts and
// compares every result; this module drives items and gives the verdict.
// ============================================================================

module tb_accumulator_machine_step_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ams_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400_000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   item;
    logic    res_valid;
    t_result res_data;
    int      fail_count;
    int      pending;
    int      sent;
    int      cycles;
    logic    no_idle;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    accumulator_machine_step_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_valid  (res_valid),
        .o_result (res_data)
    );

    ams_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_valid      (res_valid),
        .i_result     (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("accumulator_machine_step_core: mismatch");
            $finish;
        end
    end

    // One item transfer; called and returns at a falling edge, start left high
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data);
        int    gap;
        t_item nxt;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        nxt.operation = op;
        nxt.address   = addr;
        nxt.data      = data;
        start <= 1'b1;
        item  <= nxt;
        // busy only moves on rising edges, so it is settled here
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [WORD_W-1:0] instr_word(input logic [OPC_W-1:0] opc,
                                                     input logic [ADDR_W-1:0] opd);
        return {2'b00, opc, opd};
    endfunction

    // Operand values: mostly small so ADD and MUL do not always overflow
    function automatic logic [WORD_W-1:0] random_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return WORD_W'($urandom);
            default: return WORD_W'($urandom_range(1, 300));
        endcase
    endfunction

    // Instruction for a program of plen words at address 0
    function automatic logic [WORD_W-1:0] random_instr(input int plen);
        logic [OPC_W-1:0]  opc;
        logic [ADDR_W-1:0] opd;
        logic [1:0]        top_bits;
        top_bits = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 14))
            0:       opc = OPC_READ;
            1:       opc = OPC_WRITE;
            2:       opc = OPC_LOAD;
            3:       opc = OPC_STORE;
            4:       opc = OPC_ADD;
            5:       opc = OPC_SUB;
            6:       opc = OPC_DIV;
            7:       opc = OPC_MUL;
            8:       opc = OPC_JUMP;
            9:       opc = OPC_JNEG;
            10:      opc = OPC_JZ;
            11:      opc = OPC_HALT;
            12:      opc = OPC_JNS;
            default: opc = OPC_W'($urandom);
        endcase
        case (opc)
            OPC_JUMP, OPC_JNEG, OPC_JZ, OPC_JNS: begin
                if ($urandom_range(0, 7) == 0)
                    opd = ADDR_W'($urandom);
                else
                    opd = ADDR_W'($urandom_range(0, plen - 1));
            end
            default: begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: opd = ADDR_W'($urandom_range(80, MEM_WORDS - 1));
                    6, 7:             opd = ADDR_W'($urandom_range(0, plen + 3));
                    8:                opd = ADDR_W'($urandom_range(MEM_WORDS, 127));
                    default:          opd = ADDR_W'($urandom);
                endcase
            end
        endcase
        return {top_bits, opc, opd};
    endfunction

    // Stimulus
    initial begin
        int plen;
        i_rst_n = 1'b0;
        start   = 1'b0;
        item    = '0;
        sent    = 0;
        cycles  = 0;
        no_idle = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty word, memory bounds, clear
        send_item(OPER_EXEC, 7'd0, 16'h0000);
        send_item(OPER_WRITE, 7'd127, 16'hFFFF);
        send_item(OPER_READ, 7'd127, 16'h0000);
        send_item(OPER_CLEAR, 7'd0, 16'h0000);
        send_item(OPER_WRITE, 7'(MEM_WORDS - 1), 16'hFFFF);

        // Directed program: overflow, divide by zero, underflow, unknown opcode
        send_item(OPER_WRITE, 7'd0, instr_word(OPC_LOAD, 7'd99));
        send_item(OPER_WRITE, 7'd1, instr_word(OPC_ADD, 7'd99));
        send_item(OPER_WRITE, 7'd2, instr_word(OPC_DIV, 7'd98));
        send_item(OPER_WRITE, 7'd3, instr_word(OPC_DIV, 7'd99));
        send_item(OPER_WRITE, 7'd4, instr_word(OPC_SUB, 7'd99));
        send_item(OPER_WRITE, 7'd5, instr_word(OPC_JNEG, 7'd0));
        send_item(OPER_WRITE, 7'd6, instr_word(OPC_STORE, 7'd120));
        send_item(OPER_WRITE, 7'd7, instr_word(OPC_WRITE, 7'd99));
        send_item(OPER_WRITE, 7'd8, {2'b11, 7'h7F, 7'h05});
        send_item(OPER_WRITE, 7'd9, instr_word(OPC_HALT, 7'd0));
        repeat (11)
            send_item(OPER_EXEC, 7'd0, 16'hFFFF);
        send_item(OPER_READ, 7'(MEM_WORDS - 1), 16'h0000);

        // Random phases: mostly load-and-run programs, some raw items
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_item(2'($urandom), ADDR_W'($urandom), WORD_W'($urandom));
            end else begin
                plen = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                    send_item(OPER_CLEAR, ADDR_W'($urandom), WORD_W'($urandom));
                for (int i = 0; i < plen; i++)
                    send_item(OPER_WRITE, ADDR_W'(i), random_instr(plen));
                repeat ($urandom_range(0, 4))
                    send_item(OPER_WRITE, ADDR_W'($urandom_range(80, MEM_WORDS - 1)),
                              random_data());
                repeat ($urandom_range(plen, 2 * plen + 4)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(OPER_READ, ADDR_W'($urandom), WORD_W'($urandom));
                    else
                        send_item(OPER_EXEC, ADDR_W'($urandom), random_data());
                end
            end
        end

        // Drain and verdict
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("accumulator_machine_step_core: match");
        else
            $display("accumulator_machine_step_core: mismatch");
        $finish;
    end

endmodule
